// ----- hw/rtl/pps_pkg.sv -----
// Shared field widths, record layout and controller/datapath command and status types.
package pps_pkg;

  localparam int ID_W    = 8;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int RES_W   = 21;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } rec_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_init;
    logic scan_issue;
    logic jump;
    logic update;
    logic out_init;
    logic out_read;
    logic out_load;
    logic out_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sel_valid;
    logic have_next;
    logic final_finish;
    logic out_last;
  } sts_t;

endpackage

// ----- hw/rtl/pps_in_if.sv -----
// Input channel carrying one process record per transaction.
interface pps_in_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::ID_W-1:0]     proc_id;
  logic [pps_pkg::ARR_W-1:0]    arrival;
  logic [pps_pkg::BURST_W-1:0]  burst;
  logic [pps_pkg::PRIO_W-1:0]   prio;
  logic                         last_proc;

  modport source (output valid, proc_id, arrival, burst, prio, last_proc, input ready);
  modport sink   (input valid, proc_id, arrival, burst, prio, last_proc, output ready);
endinterface

// ----- hw/rtl/pps_out_if.sv -----
// Output channel carrying one per-process result record per transaction.
interface pps_out_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::ID_W-1:0]    out_proc_id;
  logic [pps_pkg::RES_W-1:0]   completion_time;
  logic [pps_pkg::RES_W-1:0]   turnaround;
  logic [pps_pkg::RES_W-1:0]   waiting;
  logic                        last_result;

  modport source (output valid, out_proc_id, completion_time, turnaround, waiting,
                  last_result, input ready);
  modport sink   (input valid, out_proc_id, completion_time, turnaround, waiting,
                  last_result, output ready);
endinterface

// ----- hw/rtl/preemptive_priority_schedule_top.sv -----
// Top level of the preemptive priority scheduler: controller, datapath and assertions.
//
//   channel   role   transaction carries
//   -------   ----   -----------------------------------------------------------
//   procs     sink   proc_id, arrival, burst, prio, last_proc
//   results   source out_proc_id, completion_time, turnaround, waiting, last_result
//
// Loading accepts one record per cycle. The transaction flagged last_proc starts the
// schedule; procs.ready stays low until the last result of the set has been taken.
// The schedule advances by segments that end at an arrival or a completion. Each
// segment is one scan of the n loaded records through the record RAM read port plus
// an update step when a process runs. Each result then passes the read, load and
// wait states, plus any stall on results.ready. Reset is synchronous and clears the
// load count, the done flags and the controller; the RAMs need no clearing pass.
module preemptive_priority_schedule_top #(
  parameter int MAX_PROCS = 16
) (
  input  logic       clk,
  input  logic       rst,
  pps_in_if.sink     procs,
  pps_out_if.source  results
);
  pps_pkg::cmd_t cmd;
  pps_pkg::sts_t sts;

  // The controller sequences the schedule; it sees only status from the datapath.
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (procs.valid),
    .in_last   (procs.last_proc),
    .in_ready  (procs.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the tables and does the selection and time arithmetic.
  pps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_proc_id     (procs.proc_id),
    .in_arrival     (procs.arrival),
    .in_burst       (procs.burst),
    .in_prio        (procs.prio),
    .res_proc_id    (results.out_proc_id),
    .res_completion (results.completion_time),
    .res_turnaround (results.turnaround),
    .res_waiting    (results.waiting),
    .res_last       (results.last_result)
  );

`ifndef ASSERT_OFF
  // Loading and result delivery never overlap.
  a_no_load_during_results: assert property (@(posedge clk) disable iff (rst)
    !(results.valid && procs.ready))
    else $error("input ready while a result is pending");

  // Time only jumps forward when some unfinished process has yet to arrive.
  a_jump_has_target: assert property (@(posedge clk) disable iff (rst)
    cmd.jump |-> sts.have_next)
    else $error("idle jump without a pending arrival");

  // After the final result transaction the block is ready for a new set.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_result) |=> procs.ready)
    else $error("not ready for a new set after the last result");
`endif
endmodule

// ----- hw/rtl/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/pps_datapath.sv -----
// Scheduler datapath: record tables, selection scan, time keeping and result formatting.
module pps_datapath #(
  parameter int MAX_PROCS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pps_pkg::cmd_t                cmd,
  output pps_pkg::sts_t                sts,
  input  logic [pps_pkg::ID_W-1:0]     in_proc_id,
  input  logic [pps_pkg::ARR_W-1:0]    in_arrival,
  input  logic [pps_pkg::BURST_W-1:0]  in_burst,
  input  logic [pps_pkg::PRIO_W-1:0]   in_prio,
  output logic [pps_pkg::ID_W-1:0]     res_proc_id,
  output logic [pps_pkg::RES_W-1:0]    res_completion,
  output logic [pps_pkg::RES_W-1:0]    res_turnaround,
  output logic [pps_pkg::RES_W-1:0]    res_waiting,
  output logic                         res_last
);
  localparam int IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W    = $clog2(MAX_PROCS + 1);
  localparam int TIME_RAW = $clog2((MAX_PROCS + 1) * (2 ** pps_pkg::ARR_W));
  localparam int TIME_W   = (TIME_RAW > pps_pkg::RES_W) ? TIME_RAW : pps_pkg::RES_W;
  localparam int REC_W    = $bits(pps_pkg::rec_t);

  logic [CNT_W-1:0]             loaded_count;
  logic [CNT_W-1:0]             n_procs;
  logic [CNT_W-1:0]             left;
  logic [TIME_W-1:0]            sim_time;
  logic [MAX_PROCS-1:0]         done_flags;
  logic [IDX_W-1:0]             scan_idx;
  logic                         cmp_valid;
  logic [IDX_W-1:0]             cmp_idx;
  logic                         sel_valid;
  logic [IDX_W-1:0]             sel_idx;
  logic [pps_pkg::PRIO_W-1:0]   sel_prio;
  logic [pps_pkg::ARR_W-1:0]    sel_arr;
  logic                         have_next;
  logic [pps_pkg::ARR_W-1:0]    next_arr;
  logic [IDX_W-1:0]             out_idx;

  logic                         full;
  logic                         wr_rec;
  logic [CNT_W-1:0]             n_load;
  logic [CNT_W-1:0]             n_m1;
  logic [pps_pkg::BURST_W-1:0]  burst_fix;
  pps_pkg::rec_t                rec_wr;
  pps_pkg::rec_t                rec_rd;
  logic [REC_W-1:0]             rec_rd_bits;
  logic [IDX_W-1:0]             rec_raddr;
  logic [pps_pkg::BURST_W-1:0]  rem_rd;
  logic [pps_pkg::BURST_W-1:0]  rem_wdata;
  logic [IDX_W-1:0]             rem_waddr;
  logic                         rem_we;
  logic [TIME_W-1:0]            fin_rd;

  logic                         arrived;
  logic                         better;
  logic [TIME_W-1:0]            gap;
  logic                         cut;
  logic [pps_pkg::BURST_W-1:0]  run;
  logic [pps_pkg::BURST_W-1:0]  rem_new;
  logic                         finish;
  logic [TIME_W-1:0]            time_after;
  logic [TIME_W-1:0]            tat;
  logic [TIME_W-1:0]            wt;

  assign full      = (loaded_count == CNT_W'(MAX_PROCS));
  assign wr_rec    = cmd.load && !full;
  assign n_load    = full ? loaded_count : loaded_count + CNT_W'(1);
  assign n_m1      = n_procs - CNT_W'(1);
  assign burst_fix = (in_burst == '0) ? pps_pkg::BURST_W'(1) : in_burst;

  always_comb begin
    rec_wr.id      = in_proc_id;
    rec_wr.arrival = in_arrival;
    rec_wr.burst   = burst_fix;
    rec_wr.prio    = in_prio;
  end

  assign rec_raddr = cmd.out_read ? out_idx : scan_idx;
  assign rec_rd    = pps_pkg::rec_t'(rec_rd_bits);

  pps_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_rec_ram (
    .clk   (clk),
    .we    (wr_rec),
    .waddr (loaded_count[IDX_W-1:0]),
    .wdata (rec_wr),
    .raddr (rec_raddr),
    .rdata (rec_rd_bits)
  );

  assign rem_we    = wr_rec || cmd.update;
  assign rem_waddr = cmd.load ? loaded_count[IDX_W-1:0] : sel_idx;
  assign rem_wdata = cmd.load ? burst_fix : rem_new;

  pps_ram #(.WIDTH(pps_pkg::BURST_W), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (sel_idx),
    .rdata (rem_rd)
  );

  pps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_fin_ram (
    .clk   (clk),
    .we    (cmd.update && finish),
    .waddr (sel_idx),
    .wdata (time_after),
    .raddr (out_idx),
    .rdata (fin_rd)
  );

  // Candidate compare for the entry whose record arrives this cycle.
  assign arrived = (TIME_W'(rec_rd.arrival) <= sim_time);
  assign better  = !sel_valid || (rec_rd.prio < sel_prio) ||
                   ((rec_rd.prio == sel_prio) && (rec_rd.arrival < sel_arr));

  // Run length: to completion, or until the next arrival if that comes first.
  assign gap        = TIME_W'(next_arr) - sim_time;
  assign cut        = have_next && (gap < TIME_W'(rem_rd));
  assign run        = cut ? gap[pps_pkg::BURST_W-1:0] : rem_rd;
  assign rem_new    = rem_rd - run;
  assign finish     = !cut;
  assign time_after = sim_time + TIME_W'(run);

  assign tat = fin_rd - TIME_W'(rec_rd.arrival);
  assign wt  = tat - TIME_W'(rec_rd.burst);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      left         <= '0;
      sim_time     <= '0;
      done_flags   <= '0;
      cmp_valid    <= 1'b0;
      sel_valid    <= 1'b0;
      have_next    <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_issue;
      if (cmd.clear) begin
        loaded_count <= '0;
        done_flags   <= '0;
      end else if (wr_rec) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (cmd.start) begin
        left     <= n_load;
        sim_time <= '0;
      end else if (cmd.jump) begin
        sim_time <= TIME_W'(next_arr);
      end else if (cmd.update) begin
        sim_time <= time_after;
        if (finish) begin
          left                <= left - CNT_W'(1);
          done_flags[sel_idx] <= 1'b1;
        end
      end
      if (cmd.scan_init) begin
        sel_valid <= 1'b0;
        have_next <= 1'b0;
      end else if (cmp_valid && !done_flags[cmp_idx]) begin
        if (arrived) begin
          if (better) begin
            sel_valid <= 1'b1;
          end
        end else if (!have_next || (rec_rd.arrival < next_arr)) begin
          have_next <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmd.start) begin
      n_procs <= n_load;
    end
    if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (!cmd.scan_init && cmp_valid && !done_flags[cmp_idx]) begin
      if (arrived) begin
        if (better) begin
          sel_idx  <= cmp_idx;
          sel_prio <= rec_rd.prio;
          sel_arr  <= rec_rd.arrival;
        end
      end else if (!have_next || (rec_rd.arrival < next_arr)) begin
        next_arr <= rec_rd.arrival;
      end
    end
    if (cmd.out_init) begin
      out_idx <= '0;
    end else if (cmd.out_next) begin
      out_idx <= out_idx + IDX_W'(1);
    end
    if (cmd.out_load) begin
      res_proc_id    <= rec_rd.id;
      res_completion <= fin_rd[pps_pkg::RES_W-1:0];
      res_turnaround <= tat[pps_pkg::RES_W-1:0];
      res_waiting    <= wt[pps_pkg::RES_W-1:0];
      res_last       <= (out_idx == n_m1[IDX_W-1:0]);
    end
  end

  always_comb begin
    sts.scan_last    = (scan_idx == n_m1[IDX_W-1:0]);
    sts.sel_valid    = sel_valid;
    sts.have_next    = have_next;
    sts.final_finish = finish && (left == CNT_W'(1));
    sts.out_last     = (out_idx == n_m1[IDX_W-1:0]);
  end
endmodule

// ----- hw/rtl/pps_ctrl.sv -----
// Scheduler controller: load, scan, decide, update and result sequencing.
module pps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pps_pkg::sts_t  sts,
  output pps_pkg::cmd_t  cmd
);
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SCAN_END = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_UPDATE   = 3'd4;
  localparam logic [2:0] S_OUT_RD   = 3'd5;
  localparam logic [2:0] S_OUT_LD   = 3'd6;
  localparam logic [2:0] S_OUT_WAIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start     = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.sel_valid) begin
          state_next = S_UPDATE;
        end else begin
          cmd.jump      = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.final_finish) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_next   = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
